FILE: sv/segregated_free_list_allocator_unit_defines.svh
// assertion macros for the segregated free list allocator
`ifndef SEGREGATED_FREE_LIST_ALLOCATOR_UNIT_DEFINES_SVH
`define SEGREGATED_FREE_LIST_ALLOCATOR_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
// property checked on every clock edge outside reset
`define SFLA_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("sfla assertion failed");
// condition that must never hold outside reset
`define SFLA_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("sfla forbidden condition");
`else
`define SFLA_ASSERT(lbl, prop)
`define SFLA_NEVER(lbl, cond)
`endif
`endif

FILE: sv/sfla_pkg.sv
// shared types, constants and class decode for the free list allocator
`default_nettype none
package sfla_pkg;
	localparam int PAGE_BYTES         = 4096;
	localparam int STORE_WORDS        = 131072;
	localparam int SMALLEST_CLASS_LOG = 3;
	localparam int LARGEST_CLASS_LOG  = 20;

	localparam int CLASS_COUNT    = LARGEST_CLASS_LOG - SMALLEST_CLASS_LOG + 1;
	localparam int CLASS_W        = $clog2(CLASS_COUNT);
	localparam int WORD_BYTES_LOG = 3;
	localparam int WORD_IDX_W     = $clog2(STORE_WORDS);
	localparam int ADDR_W         = 32;
	localparam int BLOCK_W        = ADDR_W + 2;
	localparam int HEADER_BYTES   = 8;
	localparam int CFG_IDX_W      = 2;

	localparam logic [ADDR_W-1:0]    HEAP_LIMIT_RESET = ADDR_W'(1048576);
	localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT   = CFG_IDX_W'(1);

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_OOM       = 2'd1,
		ST_NULL_FREE = 2'd2,
		ST_LEAKED    = 2'd3
	} status_t;

	typedef struct packed {
		op_t               op;
		logic [ADDR_W-1:0] req_size;
		logic [ADDR_W-1:0] block_address;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] payload_address;
		logic [ADDR_W-1:0] granted_size;
		status_t           status;
	} rsp_t;

	typedef struct packed {
		logic               fits;
		logic [CLASS_W-1:0] idx;
	} class_t;

	// smallest class whose block holds total bytes
	function automatic class_t class_for(input logic [BLOCK_W-1:0] total);
		class_t c;
		c.fits = 1'b0;
		c.idx  = '0;
		for (int k = CLASS_COUNT - 1; k >= 0; k--) begin
			if ((BLOCK_W'(1) << (k + SMALLEST_CLASS_LOG)) >= total) begin
				c.fits = 1'b1;
				c.idx  = CLASS_W'(k);
			end
		end
		return c;
	endfunction

	// store word of a byte address, higher addresses alias
	function automatic logic [WORD_IDX_W-1:0] word_index(input logic [ADDR_W-1:0] a);
		return a[WORD_BYTES_LOG +: WORD_IDX_W];
	endfunction
endpackage
`default_nettype wire

FILE: sv/sfla_word_ram.sv
// single port word store, registered read
`default_nettype none
module sfla_word_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end
endmodule
`default_nettype wire

FILE: sv/segregated_free_list_allocator_unit.sv
// Heap allocator with 18 power-of-two size classes (8 B .. 1 MiB) and a bump
// pointer. An allocate adds an 8-byte header, picks the smallest class that
// fits, pops that class's free list or cuts a new block from the bump pointer
// and writes its size into the header word. A free reads the header and
// pushes the block onto its class list, with the link kept in the first
// payload word. Headers and links live in a single-port word store of
// STORE_WORDS entries (8 bytes of address per word, addresses alias modulo
// the store); it has no reset and needs no clearing pass, so requests are
// taken right after reset. One request is in flight at a time; the next is
// accepted once the last result is loaded, which waits while the response
// register holds an undrained one. A bump allocation, an out-of-memory
// answer and a null free are answered from S_EXEC; a list pop goes on to
// S_POP and a free to S_PUSH, since the store port must first read the
// link or header and then, for a free, write the link back. Configuration
// writes are taken every cycle and should only happen while the unit is idle.
`default_nettype none
`include "segregated_free_list_allocator_unit_defines.svh"
module segregated_free_list_allocator_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// request channel
	input  wire logic                           req_valid,
	output logic                                req_ready,
	input  wire sfla_pkg::req_t                 req,
	// response channel
	output logic                                rsp_valid,
	input  wire logic                           rsp_ready,
	output sfla_pkg::rsp_t                      rsp,
	// register write channel
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [sfla_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [sfla_pkg::ADDR_W-1:0]    cfg_data
);
	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_POP,
		S_PUSH
	} state_t;

	state_t state_q, state_next;

	// configuration registers
	logic [sfla_pkg::ADDR_W-1:0] heap_base_q;
	logic [sfla_pkg::ADDR_W-1:0] heap_limit_q;

	// allocator state
	logic                        started_q;
	logic [sfla_pkg::ADDR_W-1:0] bump_q;
	logic [sfla_pkg::ADDR_W-1:0] heads_q [sfla_pkg::CLASS_COUNT];

	// request held while it is worked on
	sfla_pkg::op_t                 op_s1;
	logic                          fits_s1;
	logic [sfla_pkg::CLASS_W-1:0]  cls_s1;
	logic [sfla_pkg::BLOCK_W-1:0]  block_s1;
	logic [sfla_pkg::ADDR_W-1:0]   addr_s1;

	// response register
	logic           rsp_valid_q;
	sfla_pkg::rsp_t rsp_q;

	// store port
	logic                            ram_en;
	logic                            ram_we;
	logic [sfla_pkg::WORD_IDX_W-1:0] ram_addr;
	logic [sfla_pkg::ADDR_W-1:0]     ram_wdata;
	logic [sfla_pkg::ADDR_W-1:0]     ram_rdata;

	// decode of the incoming request
	logic                         req_fire;
	logic [sfla_pkg::ADDR_W-1:0]  size_eff;
	logic [sfla_pkg::BLOCK_W-1:0] total;
	sfla_pkg::class_t             dcls;
	logic [sfla_pkg::BLOCK_W-1:0] dblock;
	logic [sfla_pkg::ADDR_W:0]    base_up;
	logic [sfla_pkg::ADDR_W-1:0]  bump_init;

	// work on the held request
	logic [sfla_pkg::ADDR_W-1:0]  head;
	logic [sfla_pkg::ADDR_W-1:0]  pop_payload;
	logic [sfla_pkg::BLOCK_W-1:0] bump_end;
	logic                         oom;
	logic [sfla_pkg::ADDR_W-1:0]  hdr;
	sfla_pkg::class_t             fcls;
	logic                         slot_free;

	// updates decided this cycle
	logic                         rsp_load;
	sfla_pkg::rsp_t               rsp_next;
	logic                         bump_we;
	logic                         head_we;
	logic [sfla_pkg::CLASS_W-1:0] head_idx;
	logic [sfla_pkg::ADDR_W-1:0]  head_wdata;

	assign req_ready = (state_q == S_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// size 0 counts as 1; the sum is kept wide so it never wraps
	assign size_eff = (req.req_size == '0) ? sfla_pkg::ADDR_W'(1) : req.req_size;
	assign total    = sfla_pkg::BLOCK_W'(size_eff) + sfla_pkg::BLOCK_W'(sfla_pkg::HEADER_BYTES);
	assign dcls     = sfla_pkg::class_for(total);
	// classed blocks are a power of two, oversized ones round up to a multiple of 8 bytes
	assign dblock = dcls.fits
		? (sfla_pkg::BLOCK_W'(1) << (32'(dcls.idx) + sfla_pkg::SMALLEST_CLASS_LOG))
		: ((total + sfla_pkg::BLOCK_W'(7)) & ~sfla_pkg::BLOCK_W'(7));

	// first bump address: heap base rounded up to a page, saturated at the top
	assign base_up = ((sfla_pkg::ADDR_W + 1)'(heap_base_q)
		+ (sfla_pkg::ADDR_W + 1)'(sfla_pkg::PAGE_BYTES - 1))
		& ~(sfla_pkg::ADDR_W + 1)'(sfla_pkg::PAGE_BYTES - 1);
	assign bump_init = base_up[sfla_pkg::ADDR_W] ? '1 : base_up[sfla_pkg::ADDR_W-1:0];

	assign head        = heads_q[cls_s1];
	assign pop_payload = head + sfla_pkg::ADDR_W'(sfla_pkg::HEADER_BYTES);
	assign bump_end    = sfla_pkg::BLOCK_W'(bump_q) + block_s1;
	assign oom         = bump_end > sfla_pkg::BLOCK_W'(heap_limit_q);
	assign hdr         = addr_s1 - sfla_pkg::ADDR_W'(sfla_pkg::HEADER_BYTES);
	// class of the header word just read back for a free
	assign fcls        = sfla_pkg::class_for(sfla_pkg::BLOCK_W'(ram_rdata));
	// a result may be loaded when the response register is empty or drains now
	assign slot_free   = !rsp_valid_q || rsp_ready;

	always_comb begin
		state_next = state_q;
		ram_en     = 1'b0;
		ram_we     = 1'b0;
		ram_addr   = sfla_pkg::word_index(bump_q);
		ram_wdata  = block_s1[sfla_pkg::ADDR_W-1:0];
		rsp_load   = 1'b0;
		rsp_next   = '{payload_address: '0, granted_size: '0, status: sfla_pkg::ST_DONE};
		bump_we    = 1'b0;
		head_we    = 1'b0;
		head_idx   = cls_s1;
		head_wdata = ram_rdata;
		case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					state_next = S_EXEC;
				end
			end
			S_EXEC: begin
				if (op_s1 == sfla_pkg::OP_ALLOC) begin
					if (fits_s1 && head != '0) begin
						// fetch the link stored in the popped block
						ram_en     = 1'b1;
						ram_addr   = sfla_pkg::word_index(pop_payload);
						state_next = S_POP;
					end else if (slot_free) begin
						rsp_load   = 1'b1;
						state_next = S_IDLE;
						if (oom) begin
							rsp_next.status = sfla_pkg::ST_OOM;
						end else begin
							// cut from the bump pointer and stamp the header
							ram_en   = 1'b1;
							ram_we   = 1'b1;
							bump_we  = 1'b1;
							rsp_next = '{
								payload_address: bump_q
									+ sfla_pkg::ADDR_W'(sfla_pkg::HEADER_BYTES),
								granted_size:    block_s1[sfla_pkg::ADDR_W-1:0],
								status:          sfla_pkg::ST_DONE
							};
						end
					end
				end else begin
					if (addr_s1 == '0) begin
						if (slot_free) begin
							rsp_load        = 1'b1;
							rsp_next.status = sfla_pkg::ST_NULL_FREE;
							state_next      = S_IDLE;
						end
					end else begin
						// fetch the header to learn the block size
						ram_en     = 1'b1;
						ram_addr   = sfla_pkg::word_index(hdr);
						state_next = S_PUSH;
					end
				end
			end
			S_POP: begin
				if (slot_free) begin
					head_we    = 1'b1;
					rsp_load   = 1'b1;
					rsp_next   = '{
						payload_address: pop_payload,
						granted_size:    block_s1[sfla_pkg::ADDR_W-1:0],
						status:          sfla_pkg::ST_DONE
					};
					state_next = S_IDLE;
				end
			end
			S_PUSH: begin
				if (slot_free) begin
					rsp_load   = 1'b1;
					state_next = S_IDLE;
					if (!fcls.fits) begin
						rsp_next.status = sfla_pkg::ST_LEAKED;
					end else begin
						// link to the old head, then the block becomes the head
						ram_en     = 1'b1;
						ram_we     = 1'b1;
						ram_addr   = sfla_pkg::word_index(addr_s1);
						ram_wdata  = heads_q[fcls.idx];
						head_we    = 1'b1;
						head_idx   = fcls.idx;
						head_wdata = hdr;
					end
				end
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	// state and registered response
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			state_q <= state_next;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
				rsp_q       <= rsp_next;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_base_q  <= '0;
			heap_limit_q <= sfla_pkg::HEAP_LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				sfla_pkg::CFG_HEAP_BASE:  heap_base_q  <= cfg_data;
				sfla_pkg::CFG_HEAP_LIMIT: heap_limit_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// bump pointer, heap start flag and list heads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			bump_q    <= '0;
			for (int i = 0; i < sfla_pkg::CLASS_COUNT; i++) begin
				heads_q[i] <= '0;
			end
		end else begin
			// heap base only counts on the first allocate after reset
			if (req_fire && req.op == sfla_pkg::OP_ALLOC && !started_q) begin
				started_q <= 1'b1;
				bump_q    <= bump_init;
			end else if (bump_we) begin
				bump_q <= bump_end[sfla_pkg::ADDR_W-1:0];
			end
			if (head_we) begin
				heads_q[head_idx] <= head_wdata;
			end
		end
	end

	// request fields latched at accept
	always_ff @(posedge clk) begin
		if (req_fire) begin
			op_s1    <= req.op;
			fits_s1  <= dcls.fits;
			cls_s1   <= dcls.idx;
			block_s1 <= dblock;
			addr_s1  <= req.block_address;
		end
	end

	sfla_word_ram #(
		.DEPTH (sfla_pkg::STORE_WORDS),
		.WIDTH (sfla_pkg::ADDR_W)
	) u_words (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// a pop only ever starts from a non-empty list
	`SFLA_ASSERT(a_pop_nonempty, (state_q == S_POP) |-> (heads_q[cls_s1] != '0))
	// once the heap is started it stays started
	`SFLA_ASSERT(a_started_sticky, started_q |=> started_q)
	// a bump allocation never leaves the pointer beyond the limit
	`SFLA_ASSERT(a_bump_in_limit, bump_we |=> (bump_q <= heap_limit_q))
	// loading a result always ends the request
	`SFLA_ASSERT(a_result_ends_item, rsp_load |=> (state_q == S_IDLE))
	// the store port never reads while a result is loaded from a pop
	`SFLA_NEVER(a_pop_no_port, (state_q == S_POP) && ram_en)
endmodule
`default_nettype wire

FILE: dv/tb.sv
// self-checking testbench for the segregated free list allocator unit
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sfla_pkg::*;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_ready;
	req_t                 req       = '0;
	logic                 rsp_valid;
	logic                 rsp_ready = 1'b0;
	rsp_t                 rsp;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_HEAP_BASE;
	logic [ADDR_W-1:0]    cfg_data  = '0;

	segregated_free_list_allocator_unit u_dut (
		.clk,
		.arst_n,
		.req_valid,
		.req_ready,
		.req,
		.rsp_valid,
		.rsp_ready,
		.rsp,
		.cfg_valid,
		.cfg_ready,
		.cfg_index,
		.cfg_data
	);

	// idle odds in percent, changed per test
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int mismatch_count = 0;

	// mirror of the allocator: registers, list heads, bump pointer, word store
	logic [ADDR_W-1:0] base_reg   = '0;
	logic [ADDR_W-1:0] limit_reg  = HEAP_LIMIT_RESET;
	logic [ADDR_W-1:0] class_head [CLASS_COUNT] = '{default: '0};
	logic [ADDR_W-1:0] bump_ptr   = '0;
	bit                heap_open  = 1'b0;
	logic [ADDR_W-1:0] heap_store [int unsigned];
	int unsigned       touched_slots[$];

	// answers owed by the unit, oldest first
	rsp_t              pending_answers[$];
	// payload addresses handed out and not yet given back
	logic [ADDR_W-1:0] live_blocks[$];

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

	// smallest class holding total bytes, -1 when the block is oversized
	function automatic int fit_class(input logic [63:0] total);
		for (int k = 0; k < CLASS_COUNT; k++) begin
			if ((64'd1 << (k + SMALLEST_CLASS_LOG)) >= total)
				return k;
		end
		return -1;
	endfunction

	// 8 bytes per word, upper address bits alias
	function automatic int unsigned store_slot(input logic [ADDR_W-1:0] a);
		return (a >> WORD_BYTES_LOG) % STORE_WORDS;
	endfunction

	function automatic void store_write(input int unsigned slot, input logic [ADDR_W-1:0] v);
		if (!heap_store.exists(slot))
			touched_slots.push_back(slot);
		heap_store[slot] = v;
	endfunction

	function automatic req_t make_alloc(input logic [ADDR_W-1:0] size,
			input logic [ADDR_W-1:0] junk);
		req_t r;
		r.op            = OP_ALLOC;
		r.req_size      = size;
		r.block_address = junk;
		return r;
	endfunction

	function automatic req_t make_free(input logic [ADDR_W-1:0] addr,
			input logic [ADDR_W-1:0] junk);
		req_t r;
		r.op            = OP_FREE;
		r.req_size      = junk;
		r.block_address = addr;
		return r;
	endfunction

	// a request may only read store words that were written before
	function automatic bit request_is_defined(input req_t r);
		logic [63:0] total;
		int          cls;
		if (r.op == OP_FREE)
			return r.block_address == '0 ||
				heap_store.exists(store_slot(r.block_address - HEADER_BYTES));
		total = ((r.req_size == '0) ? 64'd1 : 64'(r.req_size)) + HEADER_BYTES;
		cls   = fit_class(total);
		if (cls >= 0 && class_head[cls] != '0)
			return heap_store.exists(store_slot(class_head[cls] + HEADER_BYTES));
		return 1'b1;
	endfunction

	// advance the mirror by one request and return the answer it owes
	function automatic void apply_heap_request(input req_t r, output rsp_t ans);
		logic [63:0]       total;
		logic [63:0]       blk;
		logic [63:0]       rounded;
		logic [ADDR_W-1:0] hdr;
		int                cls;
		ans        = '0;
		ans.status = ST_DONE;
		if (r.op == OP_ALLOC) begin
			// first allocate pins the heap start to a page boundary
			if (!heap_open) begin
				rounded   = ((64'(base_reg) + PAGE_BYTES - 1) / PAGE_BYTES) * PAGE_BYTES;
				bump_ptr  = (rounded > 64'hFFFF_FFFF) ? '1 : rounded[31:0];
				heap_open = 1'b1;
			end
			total = ((r.req_size == '0) ? 64'd1 : 64'(r.req_size)) + HEADER_BYTES;
			cls   = fit_class(total);
			blk   = (cls >= 0) ? (64'd1 << (cls + SMALLEST_CLASS_LOG))
				: ((total + 64'd7) & ~64'd7);
			if (cls >= 0 && class_head[cls] != '0) begin
				// reuse the head block, its link sits in the first payload word
				hdr                 = class_head[cls];
				ans.payload_address = hdr + HEADER_BYTES;
				ans.granted_size    = blk[31:0];
				class_head[cls]     = heap_store[store_slot(ans.payload_address)];
			end else if (64'(bump_ptr) + blk > 64'(limit_reg)) begin
				ans.status = ST_OOM;
			end else begin
				store_write(store_slot(bump_ptr), blk[31:0]);
				ans.payload_address = bump_ptr + HEADER_BYTES;
				ans.granted_size    = blk[31:0];
				bump_ptr            = bump_ptr + blk[31:0];
			end
		end else if (r.block_address == '0) begin
			ans.status = ST_NULL_FREE;
		end else begin
			hdr = r.block_address - HEADER_BYTES;
			cls = fit_class(64'(heap_store[store_slot(hdr)]));
			if (cls < 0) begin
				ans.status = ST_LEAKED;
			end else begin
				store_write(store_slot(r.block_address), class_head[cls]);
				class_head[cls] = hdr;
			end
		end
	endfunction

	function automatic logic [ADDR_W-1:0] pick_size();
		int r;
		r = $urandom_range(99);
		if (r < 45)
			return $urandom_range(120);
		// just at or one byte past a class edge
		if (r < 75)
			return (32'd1 << $urandom_range(LARGEST_CLASS_LOG, SMALLEST_CLASS_LOG))
				- HEADER_BYTES + $urandom_range(1);
		if (r < 95)
			return $urandom_range(65536);
		return $urandom;
	endfunction

	task automatic note_mismatch(input string what, input logic [ADDR_W-1:0] want_v,
			input logic [ADDR_W-1:0] got_v);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("mismatch on %s: expected 0x%h, got 0x%h", what, want_v, got_v);
	endtask

	task automatic check_answer(input rsp_t got);
		rsp_t want;
		if (pending_answers.size() == 0) begin
			note_mismatch("unexpected beat", '0, got.payload_address);
			return;
		end
		want = pending_answers.pop_front();
		if (got.payload_address !== want.payload_address)
			note_mismatch("payload_address", want.payload_address, got.payload_address);
		if (got.granted_size !== want.granted_size)
			note_mismatch("granted_size", want.granted_size, got.granted_size);
		if (got.status !== want.status)
			note_mismatch("status", 32'(want.status), 32'(got.status));
	endtask

	// response side: check each beat, then pick the next ready level
	initial begin
		forever begin
			@(posedge clk);
			if (rsp_valid && rsp_ready)
				check_answer(rsp);
			rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// one request beat; valid stays up when the next beat follows at once
	task automatic send_request(input req_t r, output rsp_t ans);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (!req_ready);
		apply_heap_request(r, ans);
		pending_answers.push_back(ans);
	endtask

	// only called with request valid already low
	task automatic wait_drained();
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// both registers back to back, unit idle
	task automatic set_heap_registers(input logic [ADDR_W-1:0] base,
			input logic [ADDR_W-1:0] limit);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_HEAP_BASE;
		cfg_data  <= base;
		do @(posedge clk); while (!cfg_ready);
		base_reg = base;
		cfg_index <= CFG_HEAP_LIMIT;
		cfg_data  <= limit;
		do @(posedge clk); while (!cfg_ready);
		limit_reg = limit;
		cfg_valid <= 1'b0;
	endtask

	// mostly well-formed alloc/free pairs, some null, stray and huge requests
	task automatic run_traffic(input int count);
		req_t              r;
		rsp_t              ans;
		int                pick;
		int                tries;
		int                idx;
		logic [ADDR_W-1:0] hdr;
		for (int i = 0; i < count; i++) begin
			// hold off once per run until every answer is back
			if (i == count / 2) begin
				req_valid <= 1'b0;
				wait_drained();
			end
			tries = 0;
			do begin
				r    = make_alloc(pick_size(), $urandom);
				pick = $urandom_range(99);
				if (pick >= 50 && pick < 82 && live_blocks.size() != 0) begin
					idx = $urandom_range(live_blocks.size() - 1);
					r   = make_free(live_blocks[idx], $urandom);
					live_blocks.delete(idx);
				end else if (pick >= 82 && pick < 88) begin
					r = make_free('0, $urandom);
				end else if (pick >= 88 && pick < 94 && touched_slots.size() != 0) begin
					// stray free: any address whose header word holds something
					hdr = ($urandom & 32'hFFF0_0000)
						| (touched_slots[$urandom_range(touched_slots.size() - 1)]
							<< WORD_BYTES_LOG)
						| $urandom_range(7);
					r   = make_free(hdr + HEADER_BYTES, $urandom);
				end else if (pick >= 94) begin
					r = make_alloc($urandom, $urandom);
				end
				tries++;
			end while (!request_is_defined(r) && tries < 8);
			if (!request_is_defined(r))
				r = make_free('0, $urandom);
			send_request(r, ans);
			if (r.op == OP_ALLOC && ans.status == ST_DONE)
				live_blocks.push_back(ans.payload_address);
		end
		req_valid <= 1'b0;
	endtask

	// hand-picked requests around class edges, list corners and address wrap
	task automatic test_corner_requests();
		rsp_t              a;
		rsp_t              b;
		rsp_t              c;
		rsp_t              d;
		rsp_t              ans;
		logic [ADDR_W-1:0] gap;
		send_idle_pct = 18;
		recv_idle_pct = 79;
		set_heap_registers('0, 32'h0080_0000);
		// null free before the heap exists
		send_request(make_free('0, '1), ans);
		// size zero counts as one byte, block lands at address zero
		send_request(make_alloc('0, '1), a);
		send_request(make_alloc(32'd8, '0), b);
		send_request(make_free(b.payload_address, '1), ans);
		// header at zero reads as an empty list and drops the block above
		send_request(make_free(a.payload_address, '0), ans);
		send_request(make_alloc(32'd8, $urandom), ans);
		// largest class, returned and handed out again
		send_request(make_alloc(32'h000F_FFF8, '0), c);
		send_request(make_free(c.payload_address, '0), ans);
		send_request(make_alloc(32'h000F_FFF0, '0), ans);
		// one byte past the largest class: rounded bump block, leaked on free
		send_request(make_alloc(32'h000F_FFF9, '0), d);
		send_request(make_free(d.payload_address, '1), ans);
		// wide sums that must not wrap
		send_request(make_alloc('1, '0), ans);
		send_request(make_alloc(32'hFFFF_FFF8, '1), ans);
		send_request(make_alloc(32'h0070_0000, '0), ans);
		// move the bump pointer onto the last store word, then free a
		// payload address whose header wraps below zero
		gap = ((32'h000F_FFF8 - bump_ptr) & 32'h000F_FFFF) + 32'h0010_0000;
		send_request(make_alloc(gap - HEADER_BYTES, '0), ans);
		send_request(make_alloc('0, '0), ans);
		send_request(make_free(32'd4, '0), ans);
		send_request(make_alloc(32'd8, '1), ans);
		send_request(make_alloc(32'd120, '0), a);
		send_request(make_free(a.payload_address, '0), ans);
		send_request(make_alloc(32'd100, '0), ans);
		req_valid <= 1'b0;
		wait_drained();
	endtask

	// plenty of room, slow receiver
	task automatic test_mixed_traffic();
		send_idle_pct = 18;
		recv_idle_pct = 79;
		set_heap_registers('0, 32'h0100_0000);
		run_traffic(380);
		wait_drained();
	endtask

	// zero limit: every bump fails, only list reuse succeeds; late base is ignored
	task automatic test_reuse_at_zero_limit();
		send_idle_pct = 79;
		recv_idle_pct = 18;
		set_heap_registers('1, '0);
		run_traffic(380);
		wait_drained();
	endtask

	// limit at the top of the address space, back to back beats
	task automatic test_whole_address_space();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_heap_registers($urandom, '1);
		run_traffic(390);
		wait_drained();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corner_requests();
		test_mixed_traffic();
		test_reuse_at_zero_limit();
		test_whole_address_space();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && pending_answers.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
